// ===== src/dbsh_pkg.sv =====
// Shared types and constants for the double-buffer swap handshake
`timescale 1ns / 1ps
`default_nettype none

package dbsh_pkg;

    localparam int unsigned CountWidth = 32;

    localparam logic [1:0] FUNC_NONE   = 2'd0;
    localparam logic [1:0] FUNC_SWAP   = 2'd1;
    localparam logic [1:0] FUNC_RESYNC = 2'd2;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_IDLE_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_ACK_TIMEOUT  = 2'd2;

    localparam logic [CountWidth-1:0] TIMEOUT_RESET = 32'd5000000;

    typedef struct packed {
        logic [CountWidth-1:0] timeouts_seen;
        logic [CountWidth-1:0] swaps_done;
        logic                  back_index;
        logic                  front_index;
        logic [1:0]            status;
        logic                  done_res;
        logic                  busy_res;
        logic                  sel_level;
        logic                  req_level;
    } res_t;

endpackage

`default_nettype wire

// ===== src/dbsh_core.sv =====
// Handshake state, wait timer, and swap and timeout counters, one word per accepted input
`timescale 1ns / 1ps
`default_nettype none

module dbsh_core
    import dbsh_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic [1:0]            func,
    input  wire logic                  ack_level,
    input  wire logic [CountWidth-1:0] timeout_ticks,
    output res_t                       res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_IDLE,
        PH_WAIT_ACK
    } phase_t;

    phase_t                phase_reg,   phase_next;
    logic                  req_reg,     req_next;
    logic                  sel_reg,     sel_next;
    logic                  front_reg,   front_next;
    logic [CountWidth-1:0] elapsed_reg, elapsed_next;
    logic [CountWidth-1:0] swaps_reg,   swaps_next;
    logic [CountWidth-1:0] timeouts_reg, timeouts_next;
    logic                  done;
    logic [1:0]            status;

    always_comb begin
        phase_next    = phase_reg;
        req_next      = req_reg;
        sel_next      = sel_reg;
        front_next    = front_reg;
        elapsed_next  = elapsed_reg;
        swaps_next    = swaps_reg;
        timeouts_next = timeouts_reg;
        done          = 1'b0;
        status        = ST_OK;
        if (func == FUNC_RESYNC) begin
            req_next      = ack_level;
            front_next    = 1'b0;
            sel_next      = 1'b1;
            swaps_next    = '0;
            timeouts_next = '0;
            phase_next    = PH_IDLE;
            elapsed_next  = '0;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (func == FUNC_SWAP) begin
                        phase_next   = PH_WAIT_IDLE;
                        elapsed_next = '0;
                    end
                end
                PH_WAIT_ACK: begin
                    if (ack_level == req_reg) begin
                        front_next = ~front_reg;
                        swaps_next = swaps_reg + 1'b1;
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end else if (elapsed_reg >= timeout_ticks) begin
                        timeouts_next = timeouts_reg + 1'b1;
                        done          = 1'b1;
                        status        = ST_ACK_TIMEOUT;
                        req_next      = ack_level;
                        phase_next    = PH_IDLE;
                    end else begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                default: ;
            endcase
            if (phase_next == PH_WAIT_IDLE) begin
                if (ack_level == req_reg) begin
                    sel_next     = ~front_reg;
                    req_next     = ~req_reg;
                    phase_next   = PH_WAIT_ACK;
                    elapsed_next = '0;
                end else if (elapsed_next >= timeout_ticks) begin
                    timeouts_next = timeouts_reg + 1'b1;
                    done          = 1'b1;
                    status        = ST_IDLE_TIMEOUT;
                    req_next      = ack_level;
                    phase_next    = PH_IDLE;
                end else begin
                    elapsed_next = elapsed_next + 1'b1;
                end
            end
        end
    end

    always_comb begin
        res.req_level     = req_next;
        res.sel_level     = sel_next;
        res.busy_res      = (phase_next != PH_IDLE);
        res.done_res      = done;
        res.status        = status;
        res.front_index   = front_next;
        res.back_index    = ~front_next;
        res.swaps_done    = swaps_next;
        res.timeouts_seen = timeouts_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            req_reg      <= 1'b0;
            sel_reg      <= 1'b1;
            front_reg    <= 1'b0;
            elapsed_reg  <= '0;
            swaps_reg    <= '0;
            timeouts_reg <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            req_reg      <= req_next;
            sel_reg      <= sel_next;
            front_reg    <= front_next;
            elapsed_reg  <= elapsed_next;
            swaps_reg    <= swaps_next;
            timeouts_reg <= timeouts_next;
        end
    end

    a_done_ends_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && done |=> phase_reg == PH_IDLE)
        else $error("swap still pending after done");

    a_status_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        status != ST_OK |-> done)
        else $error("status reported without done");

    a_swaps_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && func != FUNC_RESYNC && !done |=> $stable(swaps_reg))
        else $error("swap count moved without done");

    a_front_holds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(front_reg) && $stable(req_reg))
        else $error("handshake state moved without a word");

endmodule

`default_nettype wire

// ===== src/double_buffer_swap_handshake.sv =====
// The result of an accepted input word is registered and shows on m_tdata in the next cycle.
// Throughput: one word per cycle; s_tready stays high while the result register
// is empty or being taken, so the handshake state advances once per word.
// Reset (aresetn low, synchronous): req 0, select 1, front 0, no swap pending,
// counters cleared, timeout register back to 5000000, result register empty.
`timescale 1ns / 1ps
`default_nettype none

module double_buffer_swap_handshake
    import dbsh_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CountWidth-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // func [1:0], ack_level [2], zero fill [7:3]
    input  wire logic [7:0]            s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // req_level, sel_level, busy_res, done_res, status[2], front_index,
    // back_index, swaps_done[32], timeouts_seen[32]
    output logic [71:0]                m_tdata
);

    logic [CountWidth-1:0] timeout_reg;
    logic                  m_tvalid_reg;
    res_t                  res_reg;
    res_t                  res;
    logic                  accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = res_reg;

    dbsh_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .func          (s_tdata[1:0]),
        .ack_level     (s_tdata[2]),
        .timeout_ticks (timeout_reg),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire
